FILE: design/ed_pkg.sv
// Shared types and constants for the edit distance engine.
package ed_pkg;

  // Longest reference or streamed string, in bytes.
  localparam int MAX_LEN = 64;
  // Width of one row entry; it holds values from 0 to MAX_LEN.
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  // Width of the drain counter; it holds values up to MAX_LEN + 1.
  localparam int DRN_W   = $clog2(MAX_LEN + 2);
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 7;

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_STREAM = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  // Wavefront token passed from one cell to the next.
  typedef struct packed {
    logic             vld;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] left_new;  // updated row value of the left neighbor
    logic [LEN_W-1:0] left_old;  // row value of the left neighbor before the update
  } tok_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic             clr;
    logic             app;
    logic [LEN_W-1:0] app_pos;
    logic [SYM_W-1:0] app_sym;
  } cell_ctl_t;

endpackage

FILE: design/ed_cell.sv
// One cell of the systolic row: one reference byte and one row entry.
module ed_cell
  import ed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic             active_r;
  logic [SYM_W-1:0] ref_r;
  logic [LEN_W-1:0] d_r;
  logic             vld_r;
  logic [SYM_W-1:0] sym_r;
  logic [LEN_W-1:0] left_new_r;
  logic [LEN_W-1:0] left_old_r;

  logic [LEN_W:0]   up_inc;
  logic [LEN_W:0]   ins_inc;
  logic [LEN_W:0]   sub_val;
  logic [LEN_W:0]   min_a;
  logic [LEN_W:0]   min_b;
  logic [LEN_W-1:0] best;
  logic             hit_app;

  // Unit-cost recurrence: deletion, insertion or match/substitution.
  always_comb begin
    up_inc  = {1'b0, d_r} + 1'b1;
    ins_inc = {1'b0, tok_in.left_new} + 1'b1;
    sub_val = {1'b0, tok_in.left_old} + {{LEN_W{1'b0}}, (ref_r != tok_in.sym)};
    min_a   = (ins_inc < up_inc) ? ins_inc : up_inc;
    min_b   = (sub_val < min_a) ? sub_val : min_a;
    best    = min_b[LEN_W-1:0];
  end

  assign hit_app = ctl.app && (ctl.app_pos == cell_idx);

  // Control state and the row entry.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      active_r <= 1'b0;
      d_r      <= cell_idx;
      vld_r    <= 1'b0;
    end else begin
      if (hit_app) begin
        active_r <= 1'b1;
      end
      if (tok_in.vld && active_r) begin
        d_r <= best;
      end
      vld_r <= tok_in.vld;
    end
  end

  // Reference byte and the token payload handed to the right neighbor.
  always_ff @(posedge clk) begin
    if (hit_app) begin
      ref_r <= ctl.app_sym;
    end
    if (active_r) begin
      sym_r      <= tok_in.sym;
      left_new_r <= best;
      left_old_r <= d_r;
    end else begin
      sym_r      <= tok_in.sym;
      left_new_r <= tok_in.left_new;
      left_old_r <= tok_in.left_old;
    end
  end

  assign tok_out = {vld_r, sym_r, left_new_r, left_old_r};

endmodule

FILE: design/edit_distance_engine.sv
// Top level of the Levenshtein edit distance engine with its row of cells.
//
// The reference string is appended one byte per transfer into a row of
// MAX_LEN cells, then the other string is streamed one byte per transfer.
// Each streamed byte travels down the row as a wavefront, one cell per cycle,
// so stream transfers are taken every cycle. Start, append and finish
// transfers wait after the last stream transfer until the wavefront has
// left the last cell. A finish transfer gives one result the following
// cycle; the others give none. A finish also waits while the previous
// result is held by a stall on the result side; the other operations do not.
// Strings longer than MAX_LEN bytes set the overflow flag, and the distance
// then reads MAX_LEN.
module edit_distance_engine
  import ed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [SYM_W-1:0]  in_symbol,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_overflow
);

  logic [LEN_W-1:0]  ref_len_r;
  logic [LEN_W-1:0]  str_cnt_r;
  logic              ovf_r;
  logic [LEN_W-1:0]  final_r;
  logic [DRN_W-1:0]  drain_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_distance_r;
  logic              out_overflow_r;

  op_t               op;
  logic              accept;
  logic              busy;
  logic              do_start;
  logic              do_append;
  logic              do_stream;
  logic              do_finish;
  logic              ref_full;
  logic              str_full;
  logic [LEN_W-1:0]  dist_sat;
  cell_ctl_t         ctl;
  tok_t              tok_chain [MAX_LEN+1];

  assign op       = op_t'(in_op);
  assign busy     = (drain_r != '0);
  assign in_stall = (busy && (op != OP_STREAM)) ||
                    (out_valid_r && out_stall && (op == OP_FINISH));
  assign accept   = in_valid && !in_stall;

  assign ref_full = (ref_len_r == LEN_W'(MAX_LEN));
  assign str_full = (str_cnt_r == LEN_W'(MAX_LEN));

  // Decode of the accepted operation.
  always_comb begin
    do_start  = 1'b0;
    do_append = 1'b0;
    do_stream = 1'b0;
    do_finish = 1'b0;
    case (op)
      OP_START:  do_start  = accept;
      OP_APPEND: do_append = accept;
      OP_STREAM: do_stream = accept;
      OP_FINISH: do_finish = accept;
      default:   do_start  = 1'b0;
    endcase
  end

  // Broadcast control to the cells.
  always_comb begin
    ctl.clr     = do_start;
    ctl.app     = do_append && (str_cnt_r == '0) && !ref_full;
    ctl.app_pos = ref_len_r + 1'b1;
    ctl.app_sym = in_symbol;
  end

  // Token entering the first cell carries the new and old leftmost entries.
  always_comb begin
    tok_chain[0].vld      = do_stream && !str_full;
    tok_chain[0].sym      = in_symbol;
    tok_chain[0].left_new = str_cnt_r + 1'b1;
    tok_chain[0].left_old = str_cnt_r;
  end

  // The row of cells, each handing its token to the right neighbor.
  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    ed_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (LEN_W'(j)),
      .ctl      (ctl),
      .tok_in   (tok_chain[j-1]),
      .tok_out  (tok_chain[j])
    );
  end

  // Lengths, overflow flag, final row entry and wavefront drain counter.
  always_ff @(posedge clk) begin
    if (!rst_n || do_start) begin
      ref_len_r <= '0;
      str_cnt_r <= '0;
      ovf_r     <= 1'b0;
      final_r   <= '0;
      drain_r   <= '0;
    end else begin
      if (do_append && (str_cnt_r == '0)) begin
        if (ref_full) begin
          ovf_r <= 1'b1;
        end else begin
          ref_len_r <= ref_len_r + 1'b1;
          final_r   <= ref_len_r + 1'b1;
        end
      end
      if (do_stream) begin
        if (str_full) begin
          ovf_r <= 1'b1;
        end else begin
          str_cnt_r <= str_cnt_r + 1'b1;
        end
      end
      if (tok_chain[MAX_LEN].vld) begin
        final_r <= tok_chain[MAX_LEN].left_new;
      end
      if (do_stream && !str_full) begin
        drain_r <= DRN_W'(MAX_LEN + 1);
      end else if (busy) begin
        drain_r <= drain_r - 1'b1;
      end
    end
  end

  // Saturated distance for the result.
  assign dist_sat = (ovf_r || (final_r > LEN_W'(MAX_LEN))) ? LEN_W'(MAX_LEN) : final_r;

  // Output register; it frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      out_distance_r <= DIST_W'(dist_sat);
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

endmodule

FILE: sim/edit_distance_engine_test.sv
// Self-checking testbench for the edit distance engine: a directed table, then random comparisons.
module edit_distance_engine_test;
  import ed_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 635;
  localparam int QUIET_FROM     = 540;
  localparam int PLAN_LEN       = 25;

  // One reported distance.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } score_t;

  // One row of the directed table; fixed rows carry their answer, the rest are predicted.
  typedef struct packed {
    op_t        op;
    logic [7:0] sym;
    logic [7:0] reps;
    logic       fixed;
    logic [6:0] want_dst;
    logic       ovf;
  } step_t;

  localparam step_t PLAN [0:PLAN_LEN-1] = '{
    '{OP_FINISH, 8'h00, 8'd1,  1'b1, 7'd0,  1'b0},  // nothing loaded after reset
    '{OP_STREAM, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},  // stream with an empty reference
    '{OP_FINISH, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_START,  8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_APPEND, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_APPEND, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_APPEND, 8'h5A, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_STREAM, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_STREAM, 8'h5A, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_FINISH, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_APPEND, 8'h33, 8'd1,  1'b0, 7'd0,  1'b0},  // append after streaming is dropped
    '{OP_FINISH, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},  // a second finish repeats the answer
    '{OP_STREAM, 8'hA5, 8'd1,  1'b0, 7'd0,  1'b0},  // streaming goes on after a finish
    '{OP_FINISH, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_START,  8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_APPEND, 8'h00, 8'd64, 1'b0, 7'd0,  1'b0},  // full reference
    '{OP_STREAM, 8'hFF, 8'd64, 1'b0, 7'd0,  1'b0},  // full stream, every byte differs
    '{OP_FINISH, 8'h00, 8'd1,  1'b1, 7'd64, 1'b0},
    '{OP_STREAM, 8'h11, 8'd1,  1'b0, 7'd0,  1'b0},  // stream past the limit
    '{OP_FINISH, 8'h00, 8'd1,  1'b1, 7'd64, 1'b1},
    '{OP_START,  8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    '{OP_APPEND, 8'hA5, 8'd65, 1'b0, 7'd0,  1'b0},  // reference past the limit
    '{OP_FINISH, 8'h00, 8'd1,  1'b1, 7'd64, 1'b1},
    '{OP_START,  8'h00, 8'd1,  1'b0, 7'd0,  1'b0},  // start clears the overflow
    '{OP_FINISH, 8'h00, 8'd1,  1'b1, 7'd0,  1'b0}
  };

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op     = OP_START;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance;
  logic              out_overflow;

  // Predicted engine state.
  logic [SYM_W-1:0] ref_mem [0:MAX_LEN-1];
  logic [LEN_W-1:0] row [0:MAX_LEN];
  logic [LEN_W-1:0] ref_len;
  logic [LEN_W-1:0] strm_cnt;
  logic             ovf_flag;

  score_t awaited_scores [$];
  int     errors      = 0;
  int     items_in    = 0;
  int     scores_out  = 0;
  int     ovf_scores  = 0;
  int     idle_cycles = 0;
  bit     quiet       = 1'b0;
  bit     gaps_on     = 1'b1;

  edit_distance_engine uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_symbol    (in_symbol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clear both strings and reload the row with its boundary values.
  function automatic void reset_alignment();
    ref_len  = '0;
    strm_cnt = '0;
    ovf_flag = 1'b0;
    for (int j = 0; j <= MAX_LEN; j++) row[j] = LEN_W'(j);
  endfunction

  // One row of the edit distance recurrence for a streamed byte.
  function automatic void advance_row(input logic [SYM_W-1:0] sym);
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] up;
    logic [LEN_W-1:0] best;
    diag = row[0];
    strm_cnt = strm_cnt + 1'b1;
    row[0] = strm_cnt;
    for (int j = 1; j <= int'(ref_len); j++) begin
      up = row[j];
      best = up + 1'b1;
      if (row[j-1] + 1'b1 < best) best = row[j-1] + 1'b1;
      if (diag + (ref_mem[j-1] != sym) < best) best = diag + (ref_mem[j-1] != sym);
      row[j] = best;
      diag = up;
    end
  endfunction

  // Apply one accepted transfer to the predicted state; a finish yields a distance.
  function automatic void track_transfer(input op_t op, input logic [SYM_W-1:0] sym,
                                         output bit scores, output score_t score);
    scores = 1'b0;
    score  = '0;
    case (op)
      OP_START: reset_alignment();
      OP_APPEND: begin
        if (strm_cnt == 0) begin
          if (ref_len == MAX_LEN) begin
            ovf_flag = 1'b1;
          end else begin
            ref_mem[ref_len] = sym;
            ref_len = ref_len + 1'b1;
            row[ref_len] = ref_len;
          end
        end
      end
      OP_STREAM: begin
        if (strm_cnt == MAX_LEN) ovf_flag = 1'b1;
        else advance_row(sym);
      end
      OP_FINISH: begin
        scores = 1'b1;
        score.overflow = ovf_flag;
        score.distance = ovf_flag ? DIST_W'(MAX_LEN) : DIST_W'(row[ref_len]);
      end
      default: ;
    endcase
  endfunction

  // Present one item and hold it until the engine takes it.
  task automatic send_item(input op_t op, input logic [SYM_W-1:0] sym,
                           input logic fixed, input score_t fixed_score);
    bit     scores;
    score_t score;
    in_valid  <= 1'b1;
    in_op     <= op;
    in_symbol <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_in++;
    track_transfer(op, sym, scores, score);
    if (scores) awaited_scores = {awaited_scores, (fixed ? fixed_score : score)};
  endtask

  // Send with an occasional idle burst in front.
  task automatic send_paced(input op_t op, input logic [SYM_W-1:0] sym);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    send_item(op, sym, 1'b0, '0);
  endtask

  // Hold off the sender until every distance has come back.
  task automatic drain_scores();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_scores.size() != 0);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol(input bit narrow);
    logic [SYM_W-1:0] alphabet [0:3];
    alphabet = '{8'h00, 8'hFF, 8'h61, 8'h62};
    return narrow ? alphabet[$urandom_range(0, 3)] : SYM_W'($urandom_range(0, 255));
  endfunction

  // A well-formed comparison: start, reference, stream, finish, sometimes more.
  task automatic run_comparison();
    logic [SYM_W-1:0] word [0:MAX_LEN];
    int  n_ref;
    int  n_str;
    bit  narrow;
    logic [SYM_W-1:0] sym;
    narrow = $urandom_range(0, 1);
    n_ref = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_LEN - 3, MAX_LEN + 1)
                                         : $urandom_range(0, 12);
    send_paced(OP_START, pick_symbol(1'b0));
    for (int i = 0; i < n_ref; i++) begin
      word[i] = pick_symbol(narrow);
      send_paced(OP_APPEND, word[i]);
    end
    if ($urandom_range(0, 11) == 0) n_str = $urandom_range(MAX_LEN - 3, MAX_LEN + 1);
    else n_str = (n_ref + $urandom_range(0, 6) > 3) ? n_ref + $urandom_range(0, 6) - 3 : 0;
    // Streamed bytes mostly follow the reference, with edits mixed in.
    for (int i = 0; i < n_str; i++) begin
      if (i < n_ref && $urandom_range(0, 9) < 7) sym = word[i];
      else sym = pick_symbol(narrow);
      send_paced(OP_STREAM, sym);
      if ($urandom_range(0, 29) == 0) send_paced(OP_APPEND, pick_symbol(1'b0));
    end
    send_paced(OP_FINISH, pick_symbol(1'b0));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_paced(OP_STREAM, pick_symbol(narrow));
      send_paced(OP_FINISH, pick_symbol(1'b0));
    end
  endtask

  // Receiver: stall bursts with stretches of none, and no stalls near the end.
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b0;
        n = quiet ? 1 : $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 11);
      end
      repeat (n) @(posedge clk);
      if (!quiet && out_stall) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Compare each distance transfer with the oldest prediction.
  always @(posedge clk) begin
    score_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      scores_out++;
      if (out_overflow === 1'b1) ovf_scores++;
      if (awaited_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, distance %0d overflow %0b",
                 $time, out_distance, out_overflow);
      end else begin
        want = awaited_scores.pop_front();
        if (out_distance !== want.distance) begin
          errors++;
          $display("%0t: distance expected %0d, got %0d", $time, want.distance, out_distance);
        end
        if (out_overflow !== want.overflow) begin
          errors++;
          $display("%0t: overflow expected %0b, got %0b", $time, want.overflow, out_overflow);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("edit_distance_engine_test NOT OK");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random comparisons, then drain.
  initial begin : stimulus
    int directed_items;
    bit pressed;
    reset_alignment();
    for (int i = 0; i < MAX_LEN; i++) ref_mem[i] = '0;
    pressed = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_LEN; r++) begin
      for (int k = 0; k < int'(PLAN[r].reps); k++) begin
        send_item(PLAN[r].op, PLAN[r].sym, PLAN[r].fixed, {PLAN[r].want_dst, PLAN[r].ovf});
      end
    end
    directed_items = items_in;
    drain_scores();

    while (items_in < directed_items + ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 9) < 7);
      if (items_in >= directed_items + QUIET_FROM) quiet = 1'b1;
      if (!pressed && items_in >= directed_items + ITEM_TARGET / 2) begin
        pressed = 1'b1;
        drain_scores();
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_paced(op_t'($urandom_range(0, 3)), pick_symbol(1'b0));
        end
      end else begin
        run_comparison();
      end
    end
    in_valid <= 1'b0;

    while (awaited_scores.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);
    if (awaited_scores.size() != 0) begin
      errors++;
      $display("%0t: %0d distances never arrived", $time, awaited_scores.size());
    end

    $display("Sent %0d items (%0d from the directed table); checked %0d distances,",
             items_in, directed_items, scores_out);
    $display("%0d of them overflowed. Strings ran from empty to past the %0d-byte limit",
             ovf_scores, MAX_LEN);
    $display("under random idling and stalls.");
    if (errors == 0) begin
      $display("edit_distance_engine_test OK");
    end else begin
      $display("edit_distance_engine_test NOT OK");
    end
    $finish;
  end

endmodule
